>>> hdl/epm_pkg.sv
// Shared types, constants and register codes for the exact pattern matcher.
package epm_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int PATTERN_REG_BYTES = 32;
    localparam int PATTERN_WORDS = 4;
    localparam int LENGTH_W = 6;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int COUNT_W = 32;
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LENGTH  = 3'd0,
        REG_PATTERN_BYTES_0 = 3'd1,
        REG_PATTERN_BYTES_1 = 3'd2,
        REG_PATTERN_BYTES_2 = 3'd3,
        REG_PATTERN_BYTES_3 = 3'd4
    } cfg_reg_t;

    typedef logic [PATTERN_WORDS-1:0][CFG_DATA_W-1:0] pattern_words_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } text_t;

    typedef struct packed {
        logic               match_found;
        logic [COUNT_W-1:0] match_start;
        logic [COUNT_W-1:0] match_total;
        logic               text_done;
    } result_t;

endpackage

>>> hdl/exact_pattern_matcher_unit.sv
// Top level of the streaming exact pattern matcher.
// Each accepted text byte is held in the input register; its result is then
// registered. Throughput: one text byte per cycle while result_stall is low;
// the whole-window compare sits between the input and result registers.
// Reset: rst_n clears the pipeline, counters, window and configuration
// (pattern length 1, pattern bytes zero).
module exact_pattern_matcher_unit #(
    parameter int PATTERN_MAX = epm_pkg::PATTERN_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           text_valid,
    output logic                           text_stall,
    input  epm_pkg::text_t                 text,
    output logic                           result_valid,
    input  logic                           result_stall,
    output epm_pkg::result_t               result,
    input  logic                           cfg_en,
    input  logic [epm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [epm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int LEN_W = $clog2(PATTERN_MAX);
    localparam int CW = epm_pkg::COUNT_W;

    logic [epm_pkg::LENGTH_W-1:0] pattern_length_reg;
    epm_pkg::pattern_words_t      pattern_words_reg;

    logic             s1_valid_reg;
    epm_pkg::text_t   s1_data_reg;
    logic             out_valid_reg;
    epm_pkg::result_t out_data_reg;
    epm_pkg::result_t out_data_next;
    logic [CW-1:0]    seen_reg;
    logic [CW-1:0]    seen_next;
    logic [CW-1:0]    total_reg;
    logic [CW-1:0]    total_next;

    logic             accept;
    logic             advance;
    logic [LEN_W-1:0] len_m1;
    logic [CW-1:0]    len_m1_ext;
    logic             hit;
    logic             found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pattern_length_reg <= epm_pkg::LENGTH_W'(1);
            pattern_words_reg  <= '0;
        end
        else if (cfg_en) begin
            unique case (cfg_index)
                epm_pkg::REG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg_data[epm_pkg::LENGTH_W-1:0];
                epm_pkg::REG_PATTERN_BYTES_0:
                    pattern_words_reg[0] <= cfg_data;
                epm_pkg::REG_PATTERN_BYTES_1:
                    pattern_words_reg[1] <= cfg_data;
                epm_pkg::REG_PATTERN_BYTES_2:
                    pattern_words_reg[2] <= cfg_data;
                epm_pkg::REG_PATTERN_BYTES_3:
                    pattern_words_reg[3] <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    assign advance    = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign text_stall = s1_valid_reg && !advance;
    assign accept     = text_valid && !text_stall;

    epm_window #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_window (
        .clk            (clk),
        .rst_n          (rst_n),
        .shift          (advance),
        .cur_byte       (s1_data_reg.text_byte),
        .pattern_length (pattern_length_reg),
        .pattern_words  (pattern_words_reg),
        .len_m1         (len_m1),
        .hit            (hit)
    );

    assign len_m1_ext = CW'(len_m1);

    always_comb
    begin
        found = hit && (seen_reg >= len_m1_ext);

        out_data_next.match_found = found;
        if (!found)
            out_data_next.match_start = '0;
        else if (seen_reg == epm_pkg::COUNT_SAT)
            out_data_next.match_start = epm_pkg::COUNT_SAT;
        else
            out_data_next.match_start = seen_reg - len_m1_ext;

        if (found && total_reg != epm_pkg::COUNT_SAT)
            total_next = total_reg + CW'(1);
        else
            total_next = total_reg;
        out_data_next.match_total = total_next;
        out_data_next.text_done   = s1_data_reg.last_byte;

        if (s1_data_reg.last_byte)
            seen_next = '0;
        else if (seen_reg != epm_pkg::COUNT_SAT)
            seen_next = seen_reg + CW'(1);
        else
            seen_next = seen_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seen_reg      <= '0;
            total_reg     <= '0;
        end
        else begin
            s1_valid_reg  <= accept || (s1_valid_reg && !advance);
            out_valid_reg <= advance || (out_valid_reg && result_stall);
            if (advance) begin
                seen_reg  <= seen_next;
                total_reg <= s1_data_reg.last_byte ? '0 : total_next;
            end
        end
    end

    // hold payloads while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_data_reg <= text;
        if (advance)
            out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

>>> hdl/epm_window.sv
// Byte window shift line, aligned pattern registers and parallel window compare.
module epm_window #(
    parameter int PATTERN_MAX = epm_pkg::PATTERN_MAX_DEF,
    localparam int LEN_W = $clog2(PATTERN_MAX)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        shift,
    input  logic [7:0]                  cur_byte,
    input  logic [epm_pkg::LENGTH_W-1:0] pattern_length,
    input  epm_pkg::pattern_words_t     pattern_words,
    output logic [LEN_W-1:0]            len_m1,
    output logic                        hit
);

    localparam int DEPTH = PATTERN_MAX - 1;
    localparam int LEN_EXT_W = epm_pkg::LENGTH_W + 1;

    logic [7:0]           recent_reg [DEPTH];
    logic [7:0]           pbyte [PATTERN_MAX];
    logic [7:0]           aligned_reg [PATTERN_MAX];
    logic [7:0]           aligned_next [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] active_reg;
    logic [PATTERN_MAX-1:0] active_next;
    logic [LEN_W-1:0]     len_m1_reg;
    logic [LEN_W-1:0]     len_m1_next;
    logic [LEN_EXT_W-1:0] len_ext;
    logic [LEN_EXT_W-1:0] len_clamp_m1;
    logic [PATTERN_MAX-1:0] lane_ok;

    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_pbyte
        if (j < epm_pkg::PATTERN_REG_BYTES) begin : g_reg
            assign pbyte[j] = pattern_words[j / 8][(j % 8) * 8 +: 8];
        end
        else begin : g_zero
            assign pbyte[j] = '0;
        end
    end

    // clamp length into 1..PATTERN_MAX
    always_comb
    begin
        len_ext = {1'b0, pattern_length};
        if (len_ext == '0)
            len_clamp_m1 = '0;
        else if (len_ext > LEN_EXT_W'(PATTERN_MAX))
            len_clamp_m1 = LEN_EXT_W'(PATTERN_MAX - 1);
        else
            len_clamp_m1 = len_ext - LEN_EXT_W'(1);
        len_m1_next = len_clamp_m1[LEN_W-1:0];
    end

    always_comb
    begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            active_next[k] = (LEN_W'(k) <= len_m1_next);
            aligned_next[k] = active_next[k] ? pbyte[len_m1_next - LEN_W'(k)] : 8'h00;
        end
    end

    always_ff @(posedge clk)
    begin
        len_m1_reg <= len_m1_next;
        active_reg <= active_next;
        for (int k = 0; k < PATTERN_MAX; k++)
            aligned_reg[k] <= aligned_next[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < DEPTH; i++)
                recent_reg[i] <= '0;
        end
        else if (shift) begin
            recent_reg[0] <= cur_byte;
            for (int i = 1; i < DEPTH; i++)
                recent_reg[i] <= recent_reg[i-1];
        end
    end

    always_comb
    begin
        lane_ok[0] = !active_reg[0] || (aligned_reg[0] == cur_byte);
        for (int k = 1; k < PATTERN_MAX; k++)
            lane_ok[k] = !active_reg[k] || (aligned_reg[k] == recent_reg[k-1]);
    end

    assign hit = &lane_ok;
    assign len_m1 = len_m1_reg;

endmodule

>>> hdl/epm_checker.sv
// Port-level assertions for the exact pattern matcher and their bind.
module epm_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             text_stall,
    input logic             result_valid,
    input logic             result_stall,
    input epm_pkg::result_t result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result transaction changed or dropped");

    a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (!result_valid || !result_stall) |-> !text_stall)
        else $error("text stalled while result side can take a transaction");

    a_start_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.match_found |-> result.match_start == '0)
        else $error("match_start nonzero without a match");

    a_total_on_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.match_found |-> result.match_total != '0)
        else $error("match reported with zero match_total");

endmodule

bind exact_pattern_matcher_unit epm_checker u_epm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .text_stall   (text_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
